// ----- sv/assert_macros.svh -----
// assertion helpers for clocked properties on clk with synchronous rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CHK_SAME(lbl, ante, cons, msg)

`define CHK_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/tlvnps_pkg.sv -----
package tlvnps_pkg;

  localparam int DUMP_MAX_BYTES_DEF = 1024;

  localparam int DATA_W  = 8;
  localparam int PAGES_W = 10;
  localparam int OUT_W   = 2;
  localparam int LEN_W   = 16;
  localparam int SUM_W   = 17;

  localparam logic [DATA_W-1:0] CC_MAGIC = 8'hE1;
  localparam logic [DATA_W-1:0] TLV_PAD  = 8'h00;
  localparam logic [DATA_W-1:0] TLV_TERM = 8'hFE;
  localparam logic [DATA_W-1:0] TLV_LONG = 8'hFF;
  localparam logic [DATA_W-1:0] TLV_MSG  = 8'h03;

  localparam int PREFIX_BYTES = 4;
  localparam int PAGE_SHIFT   = 2;
  localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
  localparam int CC_PAGE      = 3;

  localparam logic [PAGES_W-1:0] MAX_READ_PAGE_RST = 10'd231;

  localparam logic [OUT_W-1:0] OUT_MSG    = 2'd0;
  localparam logic [OUT_W-1:0] OUT_TERM   = 2'd1;
  localparam logic [OUT_W-1:0] OUT_BAD    = 2'd2;
  localparam logic [OUT_W-1:0] OUT_RANOUT = 2'd3;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_PREFIX,
    PH_TYPE,
    PH_LEN,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_SKIP,
    PH_DONE
  } phase_t;

endpackage

// ----- sv/tlv_ndef_page_need_scanner.sv -----
// Scans a type 2 tag dump, one byte per word starting at the capability
// container page, and reports on the word flagged last_byte how many pages from
// page 3 hold the first NDEF message (or the terminator), with an outcome code:
// 0 message, 1 terminator, 2 bad magic or short dump, 3 ran out. Every byte is
// handled in the cycle it is accepted by one pass through the parse logic, so a
// word can be taken on every clock; the only stall comes from the two-deep
// result buffer (output register plus skid), which fills only when the
// consumer holds out_stall across two consecutive dump ends. A result is
// registered into the output register, or into the skid while the output is
// stalled. max_read_page may only be written between dumps.
`include "assert_macros.svh"

module tlv_ndef_page_need_scanner import tlvnps_pkg::*; #(
  parameter int DUMP_MAX_BYTES = DUMP_MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [PAGES_W-1:0] cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PAGES_W-1:0] page_count,
  output logic [OUT_W-1:0]   outcome
);

  localparam int POS_W = $clog2(DUMP_MAX_BYTES + 1);
  localparam int IDX_W = $clog2(DUMP_MAX_BYTES);
  localparam logic [POS_W-1:0] DUMP_END = POS_W'(DUMP_MAX_BYTES);

  logic [PAGES_W-1:0] max_read_page;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  phase_t             parse_phase, parse_phase_next;
  logic [IDX_W-1:0]   type_offset, type_offset_next;
  logic               msg_tlv, msg_tlv_next;
  logic [DATA_W-1:0]  length_high_byte, length_high_byte_next;
  logic [LEN_W-1:0]   skip_remaining, skip_remaining_next;
  logic [PAGES_W-1:0] decided_pages, decided_pages_next;
  logic [OUT_W-1:0]   decided_outcome, decided_outcome_next;

  logic               skid_valid;
  logic [PAGES_W-1:0] skid_pages;
  logic [OUT_W-1:0]   skid_outcome;

  logic               accept;
  logic               res_valid;
  logic [PAGES_W-1:0] res_pages;
  logic [OUT_W-1:0]   res_outcome;
  logic               out_free;

  logic [POS_W-1:0]   after_pos;
  logic [LEN_W-1:0]   vlen;
  logic [SUM_W-1:0]   len_end;
  logic [POS_W-1:0]   msg_end;
  logic [PAGES_W-1:0] msg_pages;
  logic [PAGES_W:0]   limit_wide;
  logic [PAGES_W-1:0] page_limit;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // length bookkeeping shared by short and extended length forms
  assign after_pos  = byte_position + POS_W'(1);
  assign vlen       = (parse_phase == PH_EXT_LO) ? {length_high_byte, data_byte}
                                                 : LEN_W'(data_byte);
  assign len_end    = SUM_W'(after_pos) + SUM_W'(vlen);
  assign msg_end    = (len_end > SUM_W'(DUMP_END)) ? DUMP_END : POS_W'(len_end);
  assign msg_pages  = PAGES_W'((SUM_W'(msg_end) + SUM_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
  assign limit_wide = {1'b0, max_read_page} + (PAGES_W+1)'(1);
  assign page_limit = (limit_wide >= (PAGES_W+1)'(CC_PAGE))
                      ? PAGES_W'(limit_wide - (PAGES_W+1)'(CC_PAGE)) : '0;

  always_comb begin
    byte_position_next    = byte_position;
    parse_phase_next      = parse_phase;
    type_offset_next      = type_offset;
    msg_tlv_next          = msg_tlv;
    length_high_byte_next = length_high_byte;
    skip_remaining_next   = skip_remaining;
    decided_pages_next    = decided_pages;
    decided_outcome_next  = decided_outcome;
    res_valid             = 1'b0;
    res_pages             = '0;
    res_outcome           = OUT_RANOUT;

    if (accept) begin
      if (byte_position < DUMP_END) begin
        byte_position_next = after_pos;
        unique case (parse_phase)
          PH_MAGIC: begin
            if (data_byte != CC_MAGIC) begin
              decided_pages_next   = '0;
              decided_outcome_next = OUT_BAD;
              parse_phase_next     = PH_DONE;
            end else begin
              parse_phase_next = PH_PREFIX;
            end
          end
          PH_PREFIX: begin
            if (after_pos >= POS_W'(PREFIX_BYTES)) begin
              parse_phase_next = PH_TYPE;
            end
          end
          PH_TYPE: begin
            type_offset_next = IDX_W'(byte_position);
            priority if (data_byte == TLV_PAD) begin
            end else if (data_byte == TLV_TERM) begin
              decided_pages_next   = PAGES_W'((byte_position >> PAGE_SHIFT) + POS_W'(1));
              decided_outcome_next = OUT_TERM;
              parse_phase_next     = PH_DONE;
            end else begin
              msg_tlv_next     = (data_byte == TLV_MSG);
              parse_phase_next = PH_LEN;
            end
          end
          PH_LEN, PH_EXT_LO: begin
            priority if (parse_phase == PH_LEN && data_byte == TLV_LONG) begin
              parse_phase_next = PH_EXT_HI;
            end else if (msg_tlv) begin
              decided_pages_next   = (msg_pages > page_limit) ? page_limit : msg_pages;
              decided_outcome_next = OUT_MSG;
              parse_phase_next     = PH_DONE;
            end else if (len_end > SUM_W'(17'h0FFFF)) begin
              decided_pages_next   = '0;
              decided_outcome_next = OUT_RANOUT;
              parse_phase_next     = PH_DONE;
            end else if (vlen == '0) begin
              parse_phase_next = PH_TYPE;
            end else begin
              skip_remaining_next = vlen;
              parse_phase_next    = PH_SKIP;
            end
          end
          PH_EXT_HI: begin
            length_high_byte_next = data_byte;
            parse_phase_next      = PH_EXT_LO;
          end
          PH_SKIP: begin
            skip_remaining_next = skip_remaining - LEN_W'(1);
            if (skip_remaining == LEN_W'(1)) begin
              parse_phase_next = PH_TYPE;
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end

      if (last_byte) begin
        res_valid = 1'b1;
        priority if (parse_phase_next == PH_DONE) begin
          res_pages   = decided_pages_next;
          res_outcome = decided_outcome_next;
        end else if (byte_position < POS_W'(PREFIX_BYTES)) begin
          res_outcome = OUT_BAD;
        end else begin
          res_outcome = OUT_RANOUT;
        end
        byte_position_next    = '0;
        parse_phase_next      = PH_MAGIC;
        type_offset_next      = '0;
        msg_tlv_next          = 1'b0;
        length_high_byte_next = '0;
        skip_remaining_next   = '0;
        decided_pages_next    = '0;
        decided_outcome_next  = OUT_RANOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_read_page    <= MAX_READ_PAGE_RST;
      byte_position    <= '0;
      parse_phase      <= PH_MAGIC;
      type_offset      <= '0;
      msg_tlv          <= 1'b0;
      length_high_byte <= '0;
      skip_remaining   <= '0;
      decided_pages    <= '0;
      decided_outcome  <= OUT_RANOUT;
    end else begin
      if (cfg_write_en) begin
        max_read_page <= cfg_write_data;
      end
      byte_position    <= byte_position_next;
      parse_phase      <= parse_phase_next;
      type_offset      <= type_offset_next;
      msg_tlv          <= msg_tlv_next;
      length_high_byte <= length_high_byte_next;
      skip_remaining   <= skip_remaining_next;
      decided_pages    <= decided_pages_next;
      decided_outcome  <= decided_outcome_next;
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        page_count <= skid_pages;
        outcome    <= skid_outcome;
      end else if (res_valid) begin
        page_count <= res_pages;
        outcome    <= res_outcome;
      end
    end else if (res_valid) begin
      skid_pages   <= res_pages;
      skid_outcome <= res_outcome;
    end
  end

  `CHK_SAME(a_skid_behind_out, skid_valid, out_valid, "skid holds a word while output is empty")
  `CHK_SAME(a_skip_nonzero, parse_phase == PH_SKIP, skip_remaining != '0,
            "skip phase with nothing left to skip")
  `CHK_SAME(a_fail_zero_pages, out_valid && (outcome == OUT_BAD || outcome == OUT_RANOUT),
            page_count == '0, "failure outcome with nonzero page count")
  `CHK_SAME(a_pos_bound, 1'b1, byte_position <= DUMP_END, "byte position past dump limit")
  `CHK_NEXT(a_last_clears, accept && last_byte,
            parse_phase == PH_MAGIC && byte_position == '0 && type_offset == '0,
            "parser not cleared after end of dump")

endmodule

// ----- test/tb_tlv_ndef_page_need_scanner.sv -----
`timescale 1ns / 1ps

module tb_tlv_ndef_page_need_scanner;
  import tlvnps_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [PAGES_W-1:0] pages;
    logic [OUT_W-1:0]   code;
  } page_need_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               last;
    logic               typed;
    logic [PAGES_W-1:0] pages;
    logic [OUT_W-1:0]   code;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write_en;
  logic [PAGES_W-1:0] cfg_write_data;
  logic               in_valid;
  logic               in_stall;
  logic [DATA_W-1:0]  data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PAGES_W-1:0] page_count;
  logic [OUT_W-1:0]   outcome;

  // scanner state as seen by the predictor
  logic [PAGES_W-1:0] cap_page;
  int                 pos;
  phase_t             phase;
  logic [PAGES_W-1:0] type_at;
  logic [DATA_W-1:0]  tlv_kind;
  logic [DATA_W-1:0]  len_hi;
  logic [SUM_W-1:0]   skip_left;
  logic [PAGES_W-1:0] dec_pages;
  logic [OUT_W-1:0]   dec_outcome;

  page_need_t         pending_needs[$];
  logic [DATA_W-1:0]  dump_q[$];
  page_need_t         got_need;
  int                 fails = 0;
  int                 quiet = 0;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  int                 hold_left = 0;
  logic               start_hold = 1'b0;

  dir_row_t dir_rows [26] = '{
    '{8'h3C, 1'b1, 1'b1, 10'd0, OUT_BAD},
    '{8'hE1, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFF, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFF, 1'b1, 1'b1, 10'd0, OUT_BAD},
    '{8'hE1, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFE, 1'b1, 1'b1, 10'd2, OUT_TERM},
    '{8'hE1, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h01, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFF, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFF, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFF, 1'b1, 1'b1, 10'd0, OUT_RANOUT},
    '{8'hE1, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h00, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h03, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFF, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'h03, 1'b0, 1'b0, 10'd0, OUT_MSG},
    '{8'hFC, 1'b1, 1'b0, 10'd0, OUT_MSG}
  };

  tlv_ndef_page_need_scanner i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .page_count     (page_count),
    .outcome        (outcome)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reset_scan();
    pos         = 0;
    phase       = PH_MAGIC;
    type_at     = '0;
    tlv_kind    = '0;
    len_hi      = '0;
    skip_left   = '0;
    dec_pages   = '0;
    dec_outcome = OUT_RANOUT;
  endfunction

  function automatic void settle(input logic [PAGES_W-1:0] pg, input logic [OUT_W-1:0] oc);
    dec_pages   = pg;
    dec_outcome = oc;
    phase       = PH_DONE;
  endfunction

  function automatic void length_seen(input int vlen, input int after);
    int need;
    int pages;
    int lim;
    if (tlv_kind == TLV_MSG) begin
      need = after + vlen;
      if (need > DUMP_MAX_BYTES_DEF) need = DUMP_MAX_BYTES_DEF;
      pages = (need + PAGE_BYTES - 1) / PAGE_BYTES;
      lim = (int'(cap_page) + 1 >= CC_PAGE) ? int'(cap_page) + 1 - CC_PAGE : 0;
      settle(PAGES_W'(pages > lim ? lim : pages), OUT_MSG);
    end else if (after + vlen > 'hFFFF) begin
      settle('0, OUT_RANOUT);
    end else if (vlen == 0) begin
      phase = PH_TYPE;
    end else begin
      skip_left = SUM_W'(vlen);
      phase = PH_SKIP;
    end
  endfunction

  function automatic void scan_byte(input logic [DATA_W-1:0] b, input logic last,
                                    output logic got, output logic [PAGES_W-1:0] pg,
                                    output logic [OUT_W-1:0] oc);
    int p;
    p   = pos;
    got = 1'b0;
    pg  = '0;
    oc  = '0;
    if (p < DUMP_MAX_BYTES_DEF) begin
      case (phase)
        PH_MAGIC: begin
          if (b != CC_MAGIC) settle('0, OUT_BAD);
          else phase = PH_PREFIX;
        end
        PH_PREFIX: begin
          if (p + 1 >= PREFIX_BYTES) phase = PH_TYPE;
        end
        PH_TYPE: begin
          type_at = PAGES_W'(p);
          if (b == TLV_TERM) begin
            settle(PAGES_W'((int'(type_at) + PAGE_BYTES) / PAGE_BYTES), OUT_TERM);
          end else if (b != TLV_PAD) begin
            tlv_kind = b;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == TLV_LONG) phase = PH_EXT_HI;
          else length_seen(b, p + 1);
        end
        PH_EXT_HI: begin
          len_hi = b;
          phase = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          length_seen({len_hi, b}, p + 1);
        end
        PH_SKIP: begin
          if (skip_left > 0) skip_left = skip_left - 1'b1;
          if (skip_left == 0) phase = PH_TYPE;
        end
        default: begin
        end
      endcase
      pos = p + 1;
    end
    if (last) begin
      got = 1'b1;
      if (phase == PH_DONE) begin
        pg = dec_pages;
        oc = dec_outcome;
      end else if (p < PREFIX_BYTES) begin
        oc = OUT_BAD;
      end else begin
        oc = OUT_RANOUT;
      end
      reset_scan();
    end
  endfunction

  function automatic void note_fail(input string what, input logic [PAGES_W-1:0] ep,
                                    input logic [OUT_W-1:0] ec);
    fails++;
    if (fails <= 10)
      $display("mismatch (%s): expected pages %0d outcome %0d, got pages %0d outcome %0d",
               what, ep, ec, page_count, outcome);
  endfunction

  task automatic send_word(input logic [DATA_W-1:0] b, input logic l, input logic typed,
                           input logic [PAGES_W-1:0] tp, input logic [OUT_W-1:0] tc);
    logic               got;
    logic [PAGES_W-1:0] pg;
    logic [OUT_W-1:0]   oc;
    page_need_t         e;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(b, l, got, pg, oc);
    if (got) begin
      if (typed) begin
        e.pages = tp;
        e.code  = tc;
      end else begin
        e.pages = pg;
        e.code  = oc;
      end
      pending_needs.push_back(e);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_needs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap_page(input logic [PAGES_W-1:0] v);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    cap_page = v;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (start_hold) begin
      hold_left = HOLD_CYCLES;
      start_hold = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_needs.size() == 0) begin
        note_fail("unexpected word", '0, '0);
      end else begin
        got_need = pending_needs.pop_front();
        if (page_count !== got_need.pages || outcome !== got_need.code)
          note_fail("result", got_need.pages, got_need.code);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int               s;
    int               seg_items;
    int               target;
    int               kind;
    int               len;
    int               fill_cnt;
    logic [DATA_W-1:0] t;
    logic             long_one;
    logic [PAGES_W-1:0] cfg_val;

    rst            <= 1'b1;
    in_valid       <= 1'b0;
    data_byte      <= '0;
    last_byte      <= 1'b0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    reset_scan();
    cap_page = MAX_READ_PAGE_RST;
    snd_idle_pct = 21;
    rcv_idle_pct = 83;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].pages, dir_rows[i].code);

    // flood single-word dumps while the output is held off
    snd_idle_pct = 0;
    start_hold = 1'b1;
    repeat (24) send_word(DATA_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0, '0);
    drain();

    for (s = 0; s < 6; s++) begin
      if (s < 2) begin
        snd_idle_pct = 21;
        rcv_idle_pct = 83;
      end else if (s < 4) begin
        snd_idle_pct = 83;
        rcv_idle_pct = 21;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (s)
        0: cfg_val = 10'd1023;
        1: cfg_val = 10'd0;
        2: cfg_val = 10'd2;
        3: cfg_val = 10'd3;
        4: cfg_val = PAGES_W'($urandom_range(3, 1023));
        default: cfg_val = 10'd1;
      endcase
      write_cap_page(cfg_val);
      seg_items = 0;
      long_one = (s == 3);
      while (seg_items < 60 || long_one) begin
        dump_q.delete();
        kind = $urandom_range(0, 99);
        if (!long_one && kind < 8) begin
          repeat ($urandom_range(1, 10)) dump_q.push_back(DATA_W'($urandom_range(0, 255)));
          if (kind < 4) dump_q[0] = CC_MAGIC;
        end else if (!long_one && kind < 14) begin
          dump_q.push_back(CC_MAGIC);
          repeat ($urandom_range(0, 3)) dump_q.push_back(DATA_W'($urandom_range(0, 255)));
        end else begin
          dump_q.push_back(CC_MAGIC);
          repeat (3) dump_q.push_back(DATA_W'($urandom_range(0, 255)));
          target = long_one ? $urandom_range(1026, 1040) : 0;
          fill_cnt = $urandom_range(0, 3);
          while (fill_cnt > 0 || dump_q.size() < target) begin
            if (fill_cnt > 0) fill_cnt--;
            if ($urandom_range(0, 3) == 0) begin
              repeat ($urandom_range(1, 3)) dump_q.push_back(TLV_PAD);
            end else begin
              do t = DATA_W'($urandom_range(1, 255)); while (t == TLV_MSG || t == TLV_TERM);
              dump_q.push_back(t);
              len = $urandom_range(0, long_one ? 60 : 5);
              if ($urandom_range(0, 4) == 0) begin
                dump_q.push_back(TLV_LONG);
                dump_q.push_back(8'h00);
              end
              dump_q.push_back(DATA_W'(len));
              repeat (len) dump_q.push_back(DATA_W'($urandom_range(0, 255)));
            end
          end
          kind = $urandom_range(0, 99);
          if (kind < 45) begin
            dump_q.push_back(TLV_MSG);
            if ($urandom_range(0, 3) == 0) begin
              dump_q.push_back(TLV_LONG);
              dump_q.push_back(DATA_W'($urandom_range(0, 255)));
              dump_q.push_back(DATA_W'($urandom_range(0, 255)));
            end else begin
              dump_q.push_back(DATA_W'($urandom_range(0, 254)));
            end
          end else if (kind < 75) begin
            dump_q.push_back(TLV_TERM);
          end else if (kind < 85) begin
            // long skip near the 16-bit limit
            dump_q.push_back(DATA_W'($urandom_range(4, 253)));
            dump_q.push_back(TLV_LONG);
            dump_q.push_back(8'hFF);
            dump_q.push_back(DATA_W'($urandom_range(0, 255)));
          end else if (kind < 92) begin
            dump_q.push_back(DATA_W'($urandom_range(1, 2)));
          end
          repeat ($urandom_range(0, 3)) dump_q.push_back(DATA_W'($urandom_range(0, 255)));
        end
        foreach (dump_q[i])
          send_word(dump_q[i], i == dump_q.size() - 1, 1'b0, '0, '0);
        seg_items += dump_q.size();
        long_one = 1'b0;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && pending_needs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- tlv_ndef_page_need_scanner.f -----
+incdir+sv
sv/tlvnps_pkg.sv
sv/tlv_ndef_page_need_scanner.sv
test/tb_tlv_ndef_page_need_scanner.sv
